@@ rtl/core/bfpa_pkg.sv @@
`default_nettype none
package bfpa_pkg;

	localparam int unsigned SLOTS  = 64;
	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned PAGE_W = 44;
	// Exact running sum of all chunk sizes, wide enough to never wrap
	localparam int unsigned TOT_W  = PAGE_W + SLOT_W + 1;

	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOPAGE = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ZERO   = 2'd3;

	localparam logic REG_POOL_BASE  = 1'b0;
	localparam logic REG_POOL_COUNT = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0] start;
		logic [PAGE_W-1:0] size;
		logic [SLOT_W-1:0] rank;
	} entry_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ASCAN = 6'b000010,
		S_INCR  = 6'b000100,
		S_DECR  = 6'b001000,
		S_FINAL = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

endpackage
`default_nettype wire

@@ rtl/core/bfpa_req_if.sv @@
`default_nettype none
interface bfpa_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [bfpa_pkg::PAGE_W-1:0]   page;
	logic [bfpa_pkg::PAGE_W-1:0]   count;
	modport source (output valid, command, page, count, input ready);
	modport sink (input valid, command, page, count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bfpa_rsp_if.sv @@
`default_nettype none
interface bfpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bfpa_pkg::PAGE_W-1:0]   result_page;
	logic [1:0]                    status;
	logic [bfpa_pkg::PAGE_W-1:0]   free_total;
	modport source (output valid, result_page, status, free_total, input ready);
	modport sink (input valid, result_page, status, free_total, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bfpa_ram.sv @@
`default_nettype none
module bfpa_ram #(
	parameter int unsigned DW = 8,
	parameter int unsigned AW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/best_fit_page_allocator.sv @@
// Init, no-op, rejected and ignored commands go straight from idle to the result stage.
// Free does one rank sweep over all 64 slots of the chunk memory, then a write.
// Alloc does one scan sweep (split or miss), plus a second sweep to close ranks on an exact fit.
// The single-port-read chunk memory sets the rate: one item at a time.
// The result waits in an output register; a new item is taken once the result is staged.
// arst_n clears valid bits, totals and control; the chunk memory itself is not cleared.
`default_nettype none
module best_fit_page_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_idx,
	input  wire logic [bfpa_pkg::PAGE_W-1:0] cfg_wdata,
	bfpa_req_if.sink                         req,
	bfpa_rsp_if.source                       rsp
);
	localparam int unsigned PW = bfpa_pkg::PAGE_W;
	localparam int unsigned SW = bfpa_pkg::SLOT_W;
	localparam int unsigned TW = bfpa_pkg::TOT_W;

	bfpa_pkg::state_t state_q;
	bfpa_pkg::entry_t rdata, wdata;
	logic             we;
	logic [SW-1:0]    waddr;

	logic [PW-1:0] base_q, pcount_q;
	logic [1:0]    cmd_q;
	logic [PW-1:0] page_q, cnt_q;
	logic [bfpa_pkg::SLOTS-1:0] valid_q;
	logic [TW-1:0] total_q;

	logic [SW:0]   sw_q;
	logic          p_s1;
	logic [SW-1:0] idx_s1;
	logic          issue, sweeping, hit_s1, accept;

	logic          ex_found_q, best_found_q, ff_found_q;
	logic [SW-1:0] ex_idx_q, best_idx_q, ff_idx_q, ex_rank_q, best_rank_q;
	logic [PW-1:0] ex_start_q, best_start_q, best_size_q, new_size;

	logic [PW-1:0] res_page_q;
	logic [1:0]    res_st_q;
	logic          out_valid_q;
	logic [PW-1:0] out_page_q, out_total_q;
	logic [1:0]    out_st_q;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == bfpa_pkg::S_IDLE);
	assign issue    = !sw_q[SW];
	assign sweeping = (state_q == bfpa_pkg::S_ASCAN) || (state_q == bfpa_pkg::S_INCR) ||
		(state_q == bfpa_pkg::S_DECR);
	assign hit_s1   = p_s1 && valid_q[idx_s1];
	assign new_size = best_size_q - cnt_q;

	assign rsp.valid       = out_valid_q;
	assign rsp.result_page = out_page_q;
	assign rsp.status      = out_st_q;
	assign rsp.free_total  = out_total_q;

	bfpa_ram #(.DW($bits(bfpa_pkg::entry_t)), .AW(SW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (sw_q[SW-1:0]),
		.rdata (rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			pcount_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == bfpa_pkg::REG_POOL_BASE) base_q <= cfg_wdata;
			if (cfg_idx == bfpa_pkg::REG_POOL_COUNT) pcount_q <= cfg_wdata;
		end
	end

	// Chunk memory write: rank updates during sweeps, entry loads otherwise
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		case (state_q)
			bfpa_pkg::S_IDLE: begin
				if (accept && req.command == bfpa_pkg::CMD_INIT) begin
					we    = 1'b1;
					waddr = '0;
					wdata = '{start: base_q, size: pcount_q, rank: '0};
				end
			end
			bfpa_pkg::S_INCR: begin
				we         = hit_s1;
				wdata.rank = rdata.rank + SW'(1);
			end
			bfpa_pkg::S_DECR: begin
				we         = hit_s1 && (rdata.rank > ex_rank_q);
				wdata.rank = rdata.rank - SW'(1);
			end
			bfpa_pkg::S_FINAL: begin
				if (cmd_q == bfpa_pkg::CMD_FREE) begin
					we    = 1'b1;
					waddr = ff_idx_q;
					wdata = '{start: page_q, size: cnt_q, rank: '0};
				end else if (!ex_found_q && best_found_q) begin
					we    = 1'b1;
					waddr = best_idx_q;
					wdata = '{start: best_start_q, size: new_size, rank: best_rank_q};
				end
			end
			default: ;
		endcase
	end

	// Control, sweep and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bfpa_pkg::S_IDLE;
			valid_q      <= '0;
			total_q      <= '0;
			sw_q         <= '0;
			p_s1         <= 1'b0;
			ex_found_q   <= 1'b0;
			best_found_q <= 1'b0;
			ff_found_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			p_s1 <= sweeping && issue;
			if (sweeping && issue) sw_q <= sw_q + (SW+1)'(1);
			if (rsp.valid && rsp.ready && state_q != bfpa_pkg::S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				bfpa_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q        <= req.command;
						page_q       <= req.page;
						cnt_q        <= req.count;
						res_page_q   <= '0;
						res_st_q     <= bfpa_pkg::ST_OK;
						sw_q         <= '0;
						ex_found_q   <= 1'b0;
						best_found_q <= 1'b0;
						ff_found_q   <= 1'b0;
						state_q      <= bfpa_pkg::S_OUT;
						case (req.command)
							bfpa_pkg::CMD_INIT: begin
								valid_q <= bfpa_pkg::SLOTS'(1);
								total_q <= TW'(pcount_q);
							end
							bfpa_pkg::CMD_ALLOC: begin
								if (req.count == '0) res_st_q <= bfpa_pkg::ST_ZERO;
								else state_q <= bfpa_pkg::S_ASCAN;
							end
							bfpa_pkg::CMD_FREE: begin
								if (req.page != '0) begin
									if (&valid_q) res_st_q <= bfpa_pkg::ST_FULL;
									else state_q <= bfpa_pkg::S_INCR;
								end
							end
							default: ;
						endcase
					end
				end
				bfpa_pkg::S_ASCAN: begin
					if (hit_s1) begin
						if (rdata.size == cnt_q) begin
							if (!ex_found_q || rdata.rank < ex_rank_q) begin
								ex_found_q <= 1'b1;
								ex_idx_q   <= idx_s1;
								ex_rank_q  <= rdata.rank;
								ex_start_q <= rdata.start;
							end
						end else if (rdata.size > cnt_q) begin
							if (!best_found_q || rdata.size < best_size_q ||
								(rdata.size == best_size_q && rdata.rank < best_rank_q)) begin
								best_found_q <= 1'b1;
								best_idx_q   <= idx_s1;
								best_rank_q  <= rdata.rank;
								best_start_q <= rdata.start;
								best_size_q  <= rdata.size;
							end
						end
					end
					if (!issue && !p_s1) begin
						sw_q    <= '0;
						state_q <= ex_found_q ? bfpa_pkg::S_DECR : bfpa_pkg::S_FINAL;
					end
				end
				bfpa_pkg::S_INCR: begin
					if (p_s1 && !valid_q[idx_s1] && !ff_found_q) begin
						ff_found_q <= 1'b1;
						ff_idx_q   <= idx_s1;
					end
					if (!issue && !p_s1) state_q <= bfpa_pkg::S_FINAL;
				end
				bfpa_pkg::S_DECR: begin
					if (!issue && !p_s1) state_q <= bfpa_pkg::S_FINAL;
				end
				bfpa_pkg::S_FINAL: begin
					state_q <= bfpa_pkg::S_OUT;
					if (cmd_q == bfpa_pkg::CMD_FREE) begin
						valid_q[ff_idx_q] <= 1'b1;
						total_q           <= total_q + TW'(cnt_q);
					end else if (ex_found_q) begin
						valid_q[ex_idx_q] <= 1'b0;
						res_page_q        <= ex_start_q;
						total_q           <= total_q - TW'(cnt_q);
					end else if (best_found_q) begin
						res_page_q <= best_start_q + new_size;
						total_q    <= total_q - TW'(cnt_q);
					end else begin
						res_st_q <= bfpa_pkg::ST_NOPAGE;
					end
				end
				bfpa_pkg::S_OUT: begin
					// Load the output register once it is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_page_q  <= res_page_q;
						out_st_q    <= res_st_q;
						out_total_q <= (total_q > TW'({PW{1'b1}})) ? {PW{1'b1}} : total_q[PW-1:0];
						state_q     <= bfpa_pkg::S_IDLE;
					end
				end
				default: state_q <= bfpa_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= sw_q[SW-1:0];
	end

	// Sweep write-back never hits the entry being read in the same cycle
	a_no_rmw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && sweeping && issue) |-> (waddr != sw_q[SW-1:0]))
		else $error("sweep write collides with read");

	// Init leaves exactly slot zero valid
	a_init_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == bfpa_pkg::CMD_INIT) |=> (valid_q == bfpa_pkg::SLOTS'(1)))
		else $error("init did not load one chunk");

	// A free that reaches the final write always has an empty slot
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfpa_pkg::S_FINAL && cmd_q == bfpa_pkg::CMD_FREE) |->
		(ff_found_q && !valid_q[ff_idx_q]))
		else $error("free without an empty slot");

endmodule
`default_nettype wire
